// ===== hw/rtl/ldr_pkg.sv =====
// ldr_pkg: shared constants, register codes and the lens factor table for the
// lens distortion remap unit. No dependencies; the interfaces and the top
// level use it.
`default_nettype none

package ldr_pkg;

  // sizes
  localparam int MAX_DIM    = 4096;
  localparam int TABLE_BITS = 10;
  localparam int TAB_SIZE   = (1 << TABLE_BITS) + 1;
  localparam int PIX_W      = 12;
  localparam int DIM_W      = 13;
  localparam int FRAC_W     = 16;
  localparam int F_W        = FRAC_W + 1;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 0,
    REG_IMAGE_HEIGHT = 1
  } cfg_reg_e;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  // width of the exact integer check used to settle each table entry
  localparam int CHK_W = 20 * (FRAC_W + 1) + 7 * TABLE_BITS + 4;

  // spacing of the table entries in q
  localparam real TAB_STEP = 1.0 / real'(1 << TABLE_BITS);

  typedef logic [F_W-1:0] lens_tab_t [TAB_SIZE];

  // true when y is at most round-half-up(2^16 * (i/2^tb)^0.35)
  function automatic logic tab_fits(int unsigned i, int unsigned y);
    logic [CHK_W-1:0] lhs;
    logic [CHK_W-1:0] rhs;
    if (y == 0) begin
      return 1'b1;
    end
    lhs = CHK_W'(1);
    rhs = CHK_W'(1);
    for (int k = 0; k < 20; k++) begin
      lhs = lhs * CHK_W'(2 * y - 1);
    end
    lhs = lhs << (7 * TABLE_BITS);
    for (int k = 0; k < 7; k++) begin
      rhs = rhs * CHK_W'(i);
    end
    rhs = rhs << (20 * (FRAC_W + 1));
    return (lhs <= rhs);
  endfunction

  // r^0.7 factor table, UQ1.16, estimated in real and then fixed up exactly
  function automatic lens_tab_t lens_tab_gen();
    lens_tab_t   tab;
    real         q;
    int unsigned y;
    for (int unsigned i = 0; i < TAB_SIZE; i++) begin
      q = real'(i) * TAB_STEP;
      y = $rtoi(real'(1 << FRAC_W) * (q ** 0.35) + 0.5);
      if (y > (1 << FRAC_W)) begin
        y = 1 << FRAC_W;
      end
      while (y < (1 << FRAC_W) && tab_fits(i, y + 1)) begin
        y = y + 1;
      end
      while (y > 0 && !tab_fits(i, y)) begin
        y = y - 1;
      end
      tab[i] = F_W'(y);
    end
    return tab;
  endfunction

  localparam lens_tab_t LENS_TAB = lens_tab_gen();

endpackage

`default_nettype wire

// ===== hw/rtl/ldr_if.sv =====
// ldr_if: valid/ready channel interfaces of the lens distortion remap unit:
// pixel coordinate in, source coordinate out, configuration write.
// Depends on ldr_pkg for field widths.
`default_nettype none

// output pixel coordinate channel
interface ldr_pix_if;
  logic                       valid;
  logic                       ready;
  logic [ldr_pkg::PIX_W-1:0]  pixel_x;
  logic [ldr_pkg::PIX_W-1:0]  pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

// source coordinate channel
interface ldr_src_if;
  logic                       valid;
  logic                       ready;
  logic [ldr_pkg::PIX_W-1:0]  source_x;
  logic [ldr_pkg::PIX_W-1:0]  source_y;
  logic                       remap;
  modport source (output valid, source_x, source_y, remap, input ready);
  modport sink   (input valid, source_x, source_y, remap, output ready);
endinterface

// configuration write channel
interface ldr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ldr_pkg::CFG_IDX_W-1:0]   index;
  logic [ldr_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lens_distortion_remap_unit.sv =====
// lens_distortion_remap_unit: address generator for a radial lens remap.
// Depends on ldr_pkg (constants, factor table) and ldr_if (channels).
//
// Usage:
//   pix_i carries one output pixel coordinate per word (pixel_x, pixel_y).
//   src_o returns one word per input word, in order: source_x, source_y and
//   remap. remap = 1 means copy the source pixel, remap = 0 means leave the
//   output pixel alone (sources then read zero).
//   cfg_i writes image_width (index 0) and image_height (index 1); it is
//   always ready. Write only while no word is in flight.
// Throughput: one word per cycle while src_o.ready is high. The stages are
//   the offsets, the squares, the divider set-up, the divider that forms the
//   table index (one quotient bit per pipeline stage), the table read, the
//   scaling multiply and the bounds check.
// Reset: all stages empty, image size back to 640 x 480.
// Stall: when src_o.ready is low the last stage holds its word; earlier
//   stages keep moving into empty slots, and pix_i.ready drops only once
//   every stage is full.
`default_nettype none

module lens_distortion_remap_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  ldr_pix_if.sink   pix_i,
  ldr_cfg_if.sink   cfg_i,
  ldr_src_if.source src_o
);
  import ldr_pkg::*;

  localparam int X2_W   = DIM_W + 1;
  localparam int SQF_W  = 2 * X2_W;
  localparam int SQ_W   = 2 * DIM_W;
  localparam int N_W    = SQ_W + 3;
  localparam int R_W    = SQ_W;
  localparam int IDX_W  = TABLE_BITS + 1;
  localparam int PROD_W = X2_W + F_W + 1;
  localparam int NX_W   = PROD_W + 1;
  localparam int SX_W   = NX_W - 1 - (FRAC_W + 1);

  // stage positions
  localparam int S_XY   = 0;
  localparam int S_SQ   = 1;
  localparam int S_N    = 2;
  localparam int S_ROM  = S_N + TABLE_BITS + 1;
  localparam int S_MUL  = S_ROM + 1;
  localparam int S_OUT  = S_MUL + 1;
  localparam int NSTG   = S_OUT + 1;

  // configuration registers
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_IMAGE_WIDTH) begin
        width_q <= cfg_i.data[DIM_W-1:0];
      end
      if (cfg_i.index == REG_IMAGE_HEIGHT) begin
        height_q <= cfg_i.data[DIM_W-1:0];
      end
    end
  end

  // per-stage valid bits and advance enables
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  assign en[NSTG-1] = ~v_q[NSTG-1] | src_o.ready;
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end

  assign pix_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= pix_i.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage xy: doubled offsets from the centre, lens diameter
  logic signed [X2_W-1:0] x2_d, y2_d;
  logic [DIM_W-1:0]       m_d;
  logic signed [X2_W-1:0] x2_q, y2_q;
  logic [DIM_W-1:0]       m_q;
  logic                   dim_ok_q;

  assign x2_d = $signed(X2_W'({pix_i.pixel_x, 1'b0}) - X2_W'(width_q));
  assign y2_d = $signed(X2_W'({pix_i.pixel_y, 1'b0}) - X2_W'(height_q));
  assign m_d  = (width_q < height_q) ? width_q : height_q;

  always_ff @(posedge clk_i) begin
    if (en[S_XY]) begin
      x2_q     <= x2_d;
      y2_q     <= y2_d;
      m_q      <= m_d;
      dim_ok_q <= (width_q != '0) && (height_q != '0);
    end
  end

  // stage sq: squares
  logic signed [SQF_W-1:0]  sqx_full, sqy_full;
  logic [SQ_W-1:0]          sqx_q, sqy_q, m2_q;
  logic signed [X2_W-1:0]   sx2_q, sy2_q;
  logic                     sdim_ok_q;

  assign sqx_full = SQF_W'(x2_q) * SQF_W'(x2_q);
  assign sqy_full = SQF_W'(y2_q) * SQF_W'(y2_q);

  always_ff @(posedge clk_i) begin
    if (en[S_SQ]) begin
      sqx_q     <= sqx_full[SQ_W-1:0];
      sqy_q     <= sqy_full[SQ_W-1:0];
      m2_q      <= SQ_W'(m_q) * SQ_W'(m_q);
      sx2_q     <= x2_q;
      sy2_q     <= y2_q;
      sdim_ok_q <= dim_ok_q;
    end
  end

  // stage n: lens test and divider set-up (index = 4*d2 * 2^tb / m^2)
  logic [N_W-1:0] n4;
  logic           inside_d, full_d;

  assign n4       = (N_W'(sqx_q) + N_W'(sqy_q)) << 2;
  assign inside_d = sdim_ok_q && (n4 <= N_W'(m2_q));
  assign full_d   = (n4 == N_W'(m2_q));

  logic [R_W-1:0]          dr_q   [TABLE_BITS+1];
  logic [TABLE_BITS-1:0]   dq_q   [TABLE_BITS+1];
  logic [SQ_W-1:0]         dm2_q  [TABLE_BITS+1];
  logic                    dfull_q[TABLE_BITS+1];
  logic                    din_q  [TABLE_BITS+1];
  logic signed [X2_W-1:0]  dx_q   [TABLE_BITS+1];
  logic signed [X2_W-1:0]  dy_q   [TABLE_BITS+1];

  always_ff @(posedge clk_i) begin
    if (en[S_N]) begin
      dr_q[0]    <= full_d ? '0 : n4[R_W-1:0];
      dq_q[0]    <= '0;
      dm2_q[0]   <= m2_q;
      dfull_q[0] <= full_d;
      din_q[0]   <= inside_d;
      dx_q[0]    <= sx2_q;
      dy_q[0]    <= sy2_q;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 1; j <= TABLE_BITS; j++) begin : g_div
    logic [R_W:0] r2;
    logic         ge;

    assign r2 = {dr_q[j-1], 1'b0};
    assign ge = (r2 >= {1'b0, dm2_q[j-1]});

    always_ff @(posedge clk_i) begin
      if (en[S_N + j]) begin
        dr_q[j]    <= ge ? R_W'(r2 - {1'b0, dm2_q[j-1]}) : r2[R_W-1:0];
        dq_q[j]    <= {dq_q[j-1][TABLE_BITS-2:0], ge};
        dm2_q[j]   <= dm2_q[j-1];
        dfull_q[j] <= dfull_q[j-1];
        din_q[j]   <= din_q[j-1];
        dx_q[j]    <= dx_q[j-1];
        dy_q[j]    <= dy_q[j-1];
      end
    end
  end

  // stage rom: factor lookup, registered read
  logic [IDX_W-1:0]       idx;
  logic [F_W-1:0]         f_q;
  logic                   rin_q;
  logic signed [X2_W-1:0] rx_q, ry_q;

  assign idx = dfull_q[TABLE_BITS] ? IDX_W'(1 << TABLE_BITS)
                                   : {1'b0, dq_q[TABLE_BITS]};

  always_ff @(posedge clk_i) begin
    if (en[S_ROM]) begin
      f_q   <= LENS_TAB[idx];
      rin_q <= din_q[TABLE_BITS];
      rx_q  <= dx_q[TABLE_BITS];
      ry_q  <= dy_q[TABLE_BITS];
    end
  end

  // stage mul: offset times factor
  logic signed [PROD_W-1:0] px_q, py_q;
  logic                     min_q;

  always_ff @(posedge clk_i) begin
    if (en[S_MUL]) begin
      px_q  <= PROD_W'(rx_q) * PROD_W'($signed({1'b0, f_q}));
      py_q  <= PROD_W'(ry_q) * PROD_W'($signed({1'b0, f_q}));
      min_q <= rin_q;
    end
  end

  // stage out: add centre, truncate, bounds check
  logic signed [NX_W-1:0] nx, ny;
  logic [SX_W-1:0]        sx, sy;
  logic                   ok;
  logic [PIX_W-1:0]       srcx_q, srcy_q;
  logic                   remap_q;

  assign nx = $signed(NX_W'({width_q, {FRAC_W{1'b0}}})) + NX_W'(px_q);
  assign ny = $signed(NX_W'({height_q, {FRAC_W{1'b0}}})) + NX_W'(py_q);
  assign sx = nx[NX_W-2:FRAC_W+1];
  assign sy = ny[NX_W-2:FRAC_W+1];
  assign ok = min_q && !nx[NX_W-1] && !ny[NX_W-1] &&
              (sx < SX_W'(width_q)) && (sy < SX_W'(height_q)) &&
              (sx < SX_W'(MAX_DIM)) && (sy < SX_W'(MAX_DIM));

  always_ff @(posedge clk_i) begin
    if (en[S_OUT]) begin
      srcx_q  <= ok ? sx[PIX_W-1:0] : '0;
      srcy_q  <= ok ? sy[PIX_W-1:0] : '0;
      remap_q <= ok;
    end
  end

  assign src_o.valid    = v_q[NSTG-1];
  assign src_o.source_x = srcx_q;
  assign src_o.source_y = srcy_q;
  assign src_o.remap    = remap_q;

  // checks
  a_remap_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    src_o.valid && src_o.remap |->
      (DIM_W'(src_o.source_x) < width_q) && (DIM_W'(src_o.source_y) < height_q))
    else $error("remapped source lies outside the image");

  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    src_o.valid && !src_o.remap |->
      (src_o.source_x == '0) && (src_o.source_y == '0))
    else $error("skipped pixel carries a nonzero source");

  a_block_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> src_o.valid && !src_o.ready)
    else $error("input blocked while the output side is free");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[S_ROM-1] && din_q[TABLE_BITS] |-> dr_q[TABLE_BITS] < dm2_q[TABLE_BITS])
    else $error("divider remainder not below the divisor");

  a_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[S_XY] && !en[S_XY] |=> v_q[S_XY])
    else $error("first stage dropped a stalled word");

endmodule

`default_nettype wire
